>>> hdl/triple_ema_accel_threshold_edge_assert.svh
// Assertion macros shared by the RTL modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TRIPLE_EMA_ACCEL_THRESHOLD_EDGE_ASSERT_SVH
`define TRIPLE_EMA_ACCEL_THRESHOLD_EDGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TEAT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TEAT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/teat_pkg.sv
`default_nettype none
package teat_pkg;

  localparam int FILTER_STAGES_DEF = 3;
  localparam int AXES = 3;
  localparam int SAMPLE_W = 16;
  localparam int STAGE_W = 32;
  localparam int FRAC_BITS = 15;
  localparam int ALPHA_W = 17;
  localparam int THR_W = 16;
  localparam int MAG_W = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 88;

  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd39322;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd16384;

  localparam logic [1:0] AXIS_FIRST = 2'd0;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef struct packed {
    logic capture;
    logic clear;
    logic seed;
    logic acc_clr;
    logic ema_step;
    logic ema_first;
    logic sq_step;
    logic thr_step;
    logic finish;
    logic [1:0] axis;
  } teat_cmd_t;

  typedef struct packed {
    logic seeded;
    logic out_busy;
  } teat_sts_t;

endpackage
`default_nettype wire

>>> hdl/teat_ctrl.sv
`default_nettype none
`include "triple_ema_accel_threshold_edge_assert.svh"
module teat_ctrl
  import teat_pkg::*;
#(
  parameter int FILTER_STAGES = FILTER_STAGES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic      in_tuser,
  input  wire teat_sts_t sts,
  output teat_cmd_t      cmd
);

  localparam int NST = AXES * FILTER_STAGES;
  localparam int CNT_W = $clog2(NST);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NST - 1);
  localparam logic [CNT_W-1:0] CNT_FIRST_END = CNT_W'(AXES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_EMA  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_THR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [1:0] axis_inc;

  assign in_tready = (state_r == S_IDLE);
  assign axis_inc = (axis_r == AXIS_LAST) ? AXIS_FIRST : axis_r + 2'd1;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    axis_nxt = axis_r;
    cmd = '0;
    cmd.axis = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.acc_clr = 1'b1;
        cnt_nxt = '0;
        axis_nxt = AXIS_FIRST;
        if (sts.seeded) begin
          state_nxt = S_EMA;
        end else begin
          cmd.seed = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_EMA: begin
        cmd.ema_step = 1'b1;
        cmd.ema_first = (cnt_r < CNT_FIRST_END);
        axis_nxt = axis_inc;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          axis_nxt = AXIS_FIRST;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        cmd.sq_step = 1'b1;
        axis_nxt = axis_inc;
        if (axis_r == AXIS_LAST) begin
          state_nxt = S_THR;
        end
      end
      S_THR: begin
        cmd.thr_step = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      axis_r <= AXIS_FIRST;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      axis_r <= axis_nxt;
    end
  end

  `TEAT_ASSERT_NEXT(a_sample_to_load, in_tvalid && in_tready && !in_tuser, state_r == S_LOAD, "sample transaction did not start processing")
  `TEAT_ASSERT_NEXT(a_ema_to_sqr, state_r == S_EMA && cnt_r == CNT_LAST, state_r == S_SQR && axis_r == AXIS_FIRST, "filter pass did not end on the first axis")
  `TEAT_ASSERT_NOW(a_seed_once, cmd.seed, !sts.seeded && !cmd.ema_step, "seeding an already seeded filter")

endmodule
`default_nettype wire

>>> hdl/teat_dp.sv
`default_nettype none
`include "triple_ema_accel_threshold_edge_assert.svh"
module teat_dp
  import teat_pkg::*;
#(
  parameter int FILTER_STAGES = FILTER_STAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ALPHA_W-1:0]    cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire teat_cmd_t             cmd,
  output teat_sts_t                  sts,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int NST = AXES * FILTER_STAGES;
  localparam int PROD_W = 51;

  logic [ALPHA_W-1:0] alpha_r;
  logic [THR_W-1:0] thr_r;
  logic signed [SAMPLE_W-1:0] samp_r [AXES];
  logic signed [STAGE_W-1:0] st_r [NST];
  logic seeded_r, level_r, prior_seeded_r;
  logic [MAG_W-1:0] mag_r, thr_sq_r;
  logic out_valid_r;
  logic signed [SAMPLE_W-1:0] out_f_r [AXES];
  logic [MAG_W-1:0] out_mag_r;
  logic out_above_r, out_rise_r;

  logic [ALPHA_W-1:0] alpha_eff;
  logic signed [SAMPLE_W-1:0] fin [AXES];
  logic signed [STAGE_W-1:0] ema_src;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [PROD_W-1:0] prod, prod_rnd;
  logic signed [STAGE_W-1:0] st_new;
  logic above;

  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  always_comb begin
    logic signed [32:0] rsum;
    logic signed [32:0] rq;
    for (int a = 0; a < AXES; a++) begin
      rsum = 33'(st_r[NST-AXES+a]) + 33'sd16384;
      rq = rsum >>> FRAC_BITS;
      if (rq > 33'sd32767) begin
        fin[a] = 16'sh7fff;
      end else if (rq < -33'sd32768) begin
        fin[a] = 16'sh8000;
      end else begin
        fin[a] = rq[SAMPLE_W-1:0];
      end
    end
  end

  always_comb begin
    if (cmd.ema_first) begin
      ema_src = {samp_r[cmd.axis][SAMPLE_W-1], samp_r[cmd.axis], {FRAC_BITS{1'b0}}};
    end else begin
      ema_src = st_r[NST-AXES];
    end
    if (cmd.ema_step) begin
      mul_a = 33'(ema_src) - 33'(st_r[0]);
      mul_b = 18'($signed({1'b0, alpha_eff}));
    end else if (cmd.sq_step) begin
      mul_a = 33'(fin[cmd.axis]);
      mul_b = 18'(fin[cmd.axis]);
    end else begin
      mul_a = 33'($signed({1'b0, thr_r}));
      mul_b = 18'($signed({1'b0, thr_r}));
    end
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_rnd = prod + PROD_W'(32768);
  assign st_new = st_r[0] + prod_rnd[47:16];
  assign above = (mag_r > thr_sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ALPHA: alpha_r <= cfg_wdata;
        REG_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        st_r[i] <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < NST; i++) begin
        st_r[i] <= '0;
      end
    end else if (cmd.seed) begin
      for (int i = 0; i < NST; i++) begin
        st_r[i] <= {samp_r[i % AXES][SAMPLE_W-1], samp_r[i % AXES], {FRAC_BITS{1'b0}}};
      end
    end else if (cmd.ema_step) begin
      for (int i = 0; i < NST - 1; i++) begin
        st_r[i] <= st_r[i+1];
      end
      st_r[NST-1] <= st_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp_r[0] <= in_tdata[15:0];
      samp_r[1] <= in_tdata[31:16];
      samp_r[2] <= in_tdata[47:32];
      prior_seeded_r <= seeded_r;
    end
    if (cmd.acc_clr) begin
      mag_r <= '0;
    end else if (cmd.sq_step) begin
      mag_r <= mag_r + prod[MAG_W-1:0];
    end
    if (cmd.thr_step) begin
      thr_sq_r <= prod[MAG_W-1:0];
    end
    if (cmd.finish) begin
      for (int a = 0; a < AXES; a++) begin
        out_f_r[a] <= fin[a];
      end
      out_mag_r <= mag_r;
      out_above_r <= above;
      out_rise_r <= prior_seeded_r && !level_r && above;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= 1'b0;
      level_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        seeded_r <= 1'b0;
        level_r <= 1'b0;
      end else begin
        if (cmd.seed) begin
          seeded_r <= 1'b1;
        end
        if (cmd.finish) begin
          level_r <= above;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.seeded = seeded_r;
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'b0, out_rise_r, out_above_r, out_mag_r,
                      out_f_r[2], out_f_r[1], out_f_r[0]};

  `TEAT_ASSERT_NOW(a_rise_needs_level, out_valid_r && out_rise_r, out_above_r, "rising edge reported below threshold")
  `TEAT_ASSERT_NOW(a_ema_when_seeded, cmd.ema_step, seeded_r, "filter step on an unseeded filter")
  `TEAT_ASSERT_NEXT(a_clear_flags, cmd.clear, !seeded_r && !level_r, "clear left the seed or level flag set")

endmodule
`default_nettype wire

>>> hdl/triple_ema_accel_threshold_edge.sv
// Cascaded EMA accelerometer filter with a magnitude threshold and edge flag.
// Input channel in_*: one transaction per sample or clear. in_tuser selects a
// clear (1) or a sample (0); in_tdata carries accel x, y, z as 16-bit signed.
// Output channel out_*: one transaction per sample, none for a clear.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 = alpha,
// 1 = threshold) in the same cycle; write only while the block is idle.
// An accepted sample passes the load, filter, square, threshold and finish
// states before its result is loaded into the output register; these use
// the single shared multiplier, which runs one filter step per cycle
// (three per stage) followed by three squares and the threshold square.
// A seeding sample skips the filter states. A clear is taken in the idle state.
// in_tready is high only between items, so no item is accepted before the
// last sample is finished, and the next item is accepted while a result
// waits in the output.
// If the receiver stalls, the result holds in the output register and a
// finished next item waits until that register is taken.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// filter, drops the seed and level flags and the pending result.
`default_nettype none
module triple_ema_accel_threshold_edge
  import teat_pkg::*;
#(
  parameter int FILTER_STAGES = FILTER_STAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ALPHA_W-1:0]    cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // cmd [0]
  input  wire logic [0:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // filtered_x [15:0], filtered_y [31:16], filtered_z [47:32],
  // magnitude_sq [79:48], above_threshold [80], level_rise [81], zeros above
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  teat_cmd_t cmd;
  teat_sts_t sts;

  teat_ctrl #(
    .FILTER_STAGES(FILTER_STAGES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser[0]),
    .sts      (sts),
    .cmd      (cmd)
  );

  teat_dp #(
    .FILTER_STAGES(FILTER_STAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire
